[rtl/core/assert_macros.svh]
// Assertion macros shared by the deframer RTL.
// Included by files that check their own logic; needs clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every clock edge out of reset.
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be true out of reset.
`define ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

[rtl/core/sedf_pkg.sv]
// Shared types, byte codes and the hex digit helper for the STX/ETX deframer.
// No dependencies.
`default_nettype none

package sedf_pkg;

  localparam logic [7:0] BYTE_ACK  = 8'h06;
  localparam logic [7:0] BYTE_NAK  = 8'h15;
  localparam logic [7:0] BYTE_STX  = 8'h02;
  localparam logic [7:0] BYTE_ETX  = 8'h03;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_A    = 8'h41;
  localparam logic [3:0] NIB_TEN   = 4'd10;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_ACK      = 3'd1,
    EV_NAK      = 3'd2,
    EV_PAYLOAD  = 3'd3,
    EV_GOOD     = 3'd4,
    EV_CSUM_ERR = 3'd5,
    EV_OVERFLOW = 3'd6
  } event_e;

  typedef enum logic [1:0] {
    PH_PAYLOAD = 2'd0,
    PH_HIGH    = 2'd1,
    PH_LOW     = 2'd2
  } phase_e;

  typedef struct packed {
    event_e     ev;
    logic [7:0] pay;
  } res_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] wide;
    wide = {4'd0, nib};
    return (nib < NIB_TEN) ? (CHAR_ZERO + wide) : (CHAR_A + wide - {4'd0, NIB_TEN});
  endfunction

endpackage

`default_nettype wire

[rtl/core/sedf_parser.sv]
// Frame parser: idle/frame state, running sum-8, checksum digit compare, overflow.
// Depends on sedf_pkg. Produces one result per taken word.
`default_nettype none

module sedf_parser import sedf_pkg::*; #(
  parameter int unsigned MAX_FRAME = 32
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       take_i,
  input  wire logic [7:0] rx_byte_i,
  output res_t            res_o
);

  localparam logic [5:0] MaxCount = 6'(MAX_FRAME);

  logic       in_frame_q, in_frame_d;
  phase_e     phase_q, phase_d;
  logic [7:0] sum_q, sum_d;
  logic       hi_ok_q, hi_ok_d;
  logic [5:0] count_q, count_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      phase_q    <= PH_PAYLOAD;
      sum_q      <= '0;
      hi_ok_q    <= 1'b0;
      count_q    <= '0;
    end else if (take_i) begin
      in_frame_q <= in_frame_d;
      phase_q    <= phase_d;
      sum_q      <= sum_d;
      hi_ok_q    <= hi_ok_d;
      count_q    <= count_d;
    end
  end

  // next state
  always_comb begin
    in_frame_d = in_frame_q;
    phase_d    = phase_q;
    sum_d      = sum_q;
    hi_ok_d    = hi_ok_q;
    count_d    = count_q;
    if (!in_frame_q) begin
      if (rx_byte_i == BYTE_STX) begin
        in_frame_d = 1'b1;
        phase_d    = PH_PAYLOAD;
        sum_d      = '0;
        hi_ok_d    = 1'b0;
        count_d    = '0;
      end
    end else if (count_q >= MaxCount) begin
      in_frame_d = 1'b0;
      phase_d    = PH_PAYLOAD;
      sum_d      = '0;
      hi_ok_d    = 1'b0;
      count_d    = '0;
    end else begin
      count_d = count_q + 6'd1;
      case (phase_q)
        PH_HIGH: begin
          hi_ok_d = (rx_byte_i == hex_digit(sum_q[7:4]));
          phase_d = PH_LOW;
        end
        PH_LOW: begin
          in_frame_d = 1'b0;
          phase_d    = PH_PAYLOAD;
          sum_d      = '0;
          hi_ok_d    = 1'b0;
          count_d    = '0;
        end
        default: begin
          sum_d = sum_q + rx_byte_i;
          if (rx_byte_i == BYTE_ETX) begin
            phase_d = PH_HIGH;
          end
        end
      endcase
    end
  end

  // result
  always_comb begin
    res_o.ev  = EV_NONE;
    res_o.pay = '0;
    if (!in_frame_q) begin
      if (rx_byte_i == BYTE_ACK) begin
        res_o.ev = EV_ACK;
      end else if (rx_byte_i == BYTE_NAK) begin
        res_o.ev = EV_NAK;
      end
    end else if (count_q >= MaxCount) begin
      res_o.ev = EV_OVERFLOW;
    end else begin
      case (phase_q)
        PH_HIGH: begin
          res_o.ev = EV_NONE;
        end
        PH_LOW: begin
          res_o.ev = (hi_ok_q && (rx_byte_i == hex_digit(sum_q[3:0]))) ? EV_GOOD : EV_CSUM_ERR;
        end
        default: begin
          if (rx_byte_i != BYTE_ETX) begin
            res_o.ev  = EV_PAYLOAD;
            res_o.pay = rx_byte_i;
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/core/stx_etx_ascii_checksum_deframer_core.sv]
// Each accepted word's result word is registered into the output slot, or into the skid slot while the output waits.
// Throughput: one word per cycle while in_stall_o is low; the parser state updates once per accepted byte.
// Output register plus skid register: input keeps flowing while one result waits.
// in_stall_o rises only when both output slots are full.
// Reset (rst_ni low, async) empties both slots and returns the parser to idle.
`default_nettype none

module stx_etx_ascii_checksum_deframer_core import sedf_pkg::*; #(
  parameter int unsigned MAX_FRAME = 32
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] rx_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [2:0]      event_res_o,
  output logic [7:0]      payload_byte_o
);

`include "assert_macros.svh"

  res_t res;
  logic in_take, out_pop;
  logic o_valid_q, o_valid_d, s_valid_q, s_valid_d;
  res_t o_res_q, o_res_d, s_res_q, s_res_d;

  assign in_stall_o = s_valid_q;
  assign in_take    = in_valid_i && !s_valid_q;
  assign out_pop    = o_valid_q && !out_stall_i;

  sedf_parser #(
    .MAX_FRAME(MAX_FRAME)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .take_i   (in_take),
    .rx_byte_i(rx_byte_i),
    .res_o    (res)
  );

  always_comb begin
    o_valid_d = o_valid_q;
    o_res_d   = o_res_q;
    s_valid_d = s_valid_q;
    s_res_d   = s_res_q;
    if (out_pop) begin
      if (s_valid_q) begin
        o_res_d   = s_res_q;
        s_valid_d = 1'b0;
      end else begin
        o_valid_d = in_take;
        o_res_d   = res;
      end
    end else if (in_take) begin
      if (!o_valid_q) begin
        o_valid_d = 1'b1;
        o_res_d   = res;
      end else begin
        s_valid_d = 1'b1;
        s_res_d   = res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
      s_valid_q <= 1'b0;
    end else begin
      o_valid_q <= o_valid_d;
      s_valid_q <= s_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    o_res_q <= o_res_d;
    s_res_q <= s_res_d;
  end

  assign out_valid_o    = o_valid_q;
  assign event_res_o    = o_res_q.ev;
  assign payload_byte_o = o_res_q.pay;

  `ASSERT_NEVER(a_skid_without_out, s_valid_q && !o_valid_q, "skid full while output empty")
  `ASSERT_CLK(a_take_gives_result, in_take |=> o_valid_q, "accepted word produced no result")
  `ASSERT_CLK(a_pay_zero, (o_valid_q && (o_res_q.ev != EV_PAYLOAD)) |-> (o_res_q.pay == 8'd0),
              "payload byte set on non-payload event")

endmodule

`default_nettype wire

[dv/stx_etx_ascii_checksum_deframer_core_tb.sv]
// Self-checking testbench for the STX/ETX ASCII-hex checksum deframer core.
// Drives directed and random byte streams, predicts every event word in-line.
// Depends on sedf_pkg and stx_etx_ascii_checksum_deframer_core.
`default_nettype none

module stx_etx_ascii_checksum_deframer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sedf_pkg::*;

  localparam int unsigned FRAME_CAP    = 32;
  localparam int          IDLE_PCT     = 13;
  localparam int          RANDOM_BYTES = 1500;
  localparam int          LIMIT_CYCLES = 200000;
  localparam int          REPORT_MAX   = 10;

  typedef logic [7:0] byte_q_t[$];
  typedef enum int {CK_GOOD, CK_BAD_HIGH, CK_BAD_LOW, CK_LOWER, CK_JUNK} csum_mode_e;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] rx_byte_i = 8'h00;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [2:0] event_res_o;
  logic [7:0] payload_byte_o;

  // predictor state
  logic       rx_in_frame;
  phase_e     rx_phase;
  logic [7:0] rx_sum;
  logic       rx_hi_ok;
  logic [5:0] rx_count;

  res_t expected_words[$];
  res_t want;
  int   ev_count[0:7];
  int   errors;
  int   bytes_sent;
  int   cycle_count;
  bit   calm;

  stx_etx_ascii_checksum_deframer_core #(
    .MAX_FRAME(FRAME_CAP)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .event_res_o   (event_res_o),
    .payload_byte_o(payload_byte_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_words.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("unexpected word: ev=%0d pay=%02h", event_res_o, payload_byte_o);
      end else begin
        want = expected_words.pop_front();
        if (event_res_o !== want.ev || payload_byte_o !== want.pay) begin
          errors++;
          if (errors <= REPORT_MAX)
            $display("word mismatch: expected ev=%0d pay=%02h, got ev=%0d pay=%02h",
                     want.ev, want.pay, event_res_o, payload_byte_o);
        end
      end
    end
  end

  function automatic logic [7:0] nibble_char(input logic [3:0] n);
    if (n < 4'd10) return CHAR_ZERO + {4'd0, n};
    return CHAR_A + {4'd0, n} - 8'd10;
  endfunction

  function automatic void clear_frame();
    rx_phase = PH_PAYLOAD;
    rx_sum   = 8'h00;
    rx_hi_ok = 1'b0;
    rx_count = 6'd0;
  endfunction

  function automatic res_t deframe_byte(input logic [7:0] b);
    res_t r;
    r.ev  = EV_NONE;
    r.pay = 8'h00;
    if (!rx_in_frame) begin
      case (b)
        BYTE_ACK: r.ev = EV_ACK;
        BYTE_NAK: r.ev = EV_NAK;
        BYTE_STX: begin
          rx_in_frame = 1'b1;
          clear_frame();
        end
        default: ;
      endcase
    end else if (rx_count >= FRAME_CAP) begin
      r.ev = EV_OVERFLOW;
      rx_in_frame = 1'b0;
      clear_frame();
    end else begin
      rx_count = rx_count + 6'd1;
      case (rx_phase)
        PH_HIGH: begin
          rx_hi_ok = (b == nibble_char(rx_sum[7:4]));
          rx_phase = PH_LOW;
        end
        PH_LOW: begin
          if (rx_hi_ok && b == nibble_char(rx_sum[3:0])) r.ev = EV_GOOD;
          else r.ev = EV_CSUM_ERR;
          rx_in_frame = 1'b0;
          clear_frame();
        end
        default: begin
          rx_sum = rx_sum + b;
          if (b == BYTE_ETX) begin
            rx_phase = PH_HIGH;
          end else begin
            r.ev  = EV_PAYLOAD;
            r.pay = b;
          end
        end
      endcase
    end
    ev_count[r.ev]++;
    return r;
  endfunction

  function automatic byte_q_t random_body(input int n);
    byte_q_t q;
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      do b = 8'($urandom); while (b == BYTE_ETX);
      q.push_back(b);
    end
    return q;
  endfunction

  // called at a falling edge, returns at a falling edge with valid still high
  task automatic send_byte(input logic [7:0] b);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      rx_byte_i  <= 8'($urandom);
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    expected_words.push_back(deframe_byte(b));
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_for_results();
    if (expected_words.size() != 0) begin
      in_valid_i <= 1'b0;
      while (expected_words.size() != 0) @(negedge clk_i);
    end
  endtask

  task automatic send_frame(input byte_q_t body, input csum_mode_e mode);
    logic [7:0] csum;
    logic [7:0] hi;
    logic [7:0] lo;
    csum = BYTE_ETX;
    foreach (body[i]) csum += body[i];
    hi = nibble_char(csum[7:4]);
    lo = nibble_char(csum[3:0]);
    case (mode)
      CK_BAD_HIGH: hi ^= 8'(1 << $urandom_range(0, 7));
      CK_BAD_LOW:  lo ^= 8'(1 << $urandom_range(0, 7));
      CK_LOWER: begin
        hi |= 8'h20;
        lo |= 8'h20;
      end
      CK_JUNK: begin
        hi = 8'($urandom);
        lo = 8'($urandom);
      end
      default: ;
    endcase
    send_byte(BYTE_STX);
    foreach (body[i]) send_byte(body[i]);
    send_byte(BYTE_ETX);
    send_byte(hi);
    send_byte(lo);
  endtask

  task automatic send_unterminated(input int n);
    byte_q_t body;
    body = random_body(n);
    send_byte(BYTE_STX);
    foreach (body[i]) send_byte(body[i]);
  endtask

  task automatic test_idle_bytes();
    send_byte(BYTE_ACK);
    send_byte(BYTE_NAK);
    send_byte(8'h00);
    send_byte(8'hFF);
    wait_for_results();
  endtask

  task automatic test_good_frame();
    byte_q_t body;
    body = {8'h00, 8'hFF, BYTE_ACK, BYTE_NAK, BYTE_STX};
    send_frame(body, CK_GOOD);
    wait_for_results();
  endtask

  task automatic test_checksum_errors();
    byte_q_t body;
    body = {8'h07};
    send_frame(body, CK_LOWER);
    body.delete();
    send_frame(body, CK_BAD_HIGH);
    body = {8'h10};
    send_frame(body, CK_BAD_LOW);
    wait_for_results();
  endtask

  // frame of exactly the frame limit, one byte too many, and a runaway frame
  task automatic test_overflow();
    send_frame(random_body(FRAME_CAP - 3), CK_GOOD);
    send_frame(random_body(FRAME_CAP - 2), CK_GOOD);
    send_unterminated(FRAME_CAP + 1);
    wait_for_results();
  endtask

  task automatic test_random_traffic();
    int start;
    int pick;
    int len;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) begin
      calm = (bytes_sent - start > 600) && (bytes_sent - start < 900);
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        len = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 12)
                                           : $urandom_range(FRAME_CAP - 6, FRAME_CAP + 2);
        send_frame(random_body(len), ($urandom_range(0, 99) < 75)
                   ? CK_GOOD : csum_mode_e'($urandom_range(1, 4)));
      end else if (pick < 72) begin
        repeat ($urandom_range(1, 4)) begin
          case ($urandom_range(0, 2))
            0:       send_byte(BYTE_ACK);
            1:       send_byte(BYTE_NAK);
            default: send_byte(8'($urandom));
          endcase
        end
      end else if (pick < 84) begin
        send_byte(BYTE_STX);
        repeat ($urandom_range(0, 8)) send_byte(8'($urandom));
      end else if (pick < 96) begin
        send_unterminated($urandom_range(FRAME_CAP, FRAME_CAP + 4));
      end else begin
        wait_for_results();
      end
    end
    calm = 1'b0;
    wait_for_results();
  endtask

  initial begin
    rx_in_frame = 1'b0;
    clear_frame();
    foreach (ev_count[i]) ev_count[i] = 0;
    errors      = 0;
    bytes_sent  = 0;
    cycle_count = 0;
    calm        = 1'b0;
    rst_ni      = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_idle_bytes();
    test_good_frame();
    test_checksum_errors();
    test_overflow();
    test_random_traffic();

    repeat (8) @(posedge clk_i);
    $display("Sent %0d bytes: %0d payload, %0d ack, %0d nak, %0d ignored.",
             bytes_sent, ev_count[EV_PAYLOAD], ev_count[EV_ACK], ev_count[EV_NAK],
             ev_count[EV_NONE]);
    $display("Frames closed: %0d good, %0d checksum errors, %0d overflows; %0d mismatches.",
             ev_count[EV_GOOD], ev_count[EV_CSUM_ERR], ev_count[EV_OVERFLOW], errors);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
